// ===== hw/rtl/utrcd_pkg.sv =====
// Shared constants, command codes and control structs for the UART transmit ring.
`timescale 1ns / 1ps
package utrcd_pkg;

  // Ring depth must be a power of two; one slot always stays empty.
  localparam int RING_DEPTH  = 4096;
  localparam int BURST_BYTES = 16;
  localparam int PTR_W       = $clog2(RING_DEPTH);
  localparam int CNT_W       = $clog2(BURST_BYTES + 1);
  localparam int PEND_W      = 12;
  localparam int BUDGET_W    = 16;
  localparam int BYTE_W      = 8;

  localparam logic [1:0] CMD_ENQ       = 2'd0;
  localparam logic [1:0] CMD_DRAIN     = 2'd1;
  localparam logic [1:0] CMD_READY     = 2'd2;
  localparam logic [1:0] CMD_NOT_READY = 2'd3;

  localparam logic KIND_STATUS = 1'b0;
  localparam logic KIND_BYTE   = 1'b1;

  localparam logic [BYTE_W-1:0]   LF_BYTE          = 8'h0A;
  localparam logic [BYTE_W-1:0]   CR_BYTE          = 8'h0D;
  localparam logic [BUDGET_W-1:0] BUDGET_UNLIMITED = 16'hFFFF;

  typedef struct packed {
    logic accept;   // input request taken this cycle
    logic wr_lf;    // write the line feed after its carriage return
    logic rd;       // read ring at read pointer
    logic ld;       // load read byte into output register
  } dp_cmd_t;

  typedef struct packed {
    logic enq_two;      // enqueue would store CR plus LF
    logic burst_go;     // ready request has bytes to send
    logic remain_last;  // one burst byte left
    logic out_free;     // output register can take a result
  } dp_stat_t;

endpackage

// ===== hw/rtl/utrcd_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
module utrcd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/utrcd_dp.sv =====
// Datapath: ring pointers, budget, drop latch, ring memory and result register.
`timescale 1ns / 1ps
module utrcd_dp import utrcd_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  dp_cmd_t             dcmd,
  output dp_stat_t            stat,
  input  logic [1:0]          cmd,
  input  logic [BYTE_W-1:0]   byte_in,
  input  logic                end_of_write,
  input  logic [BUDGET_W-1:0] budget,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                kind,
  output logic [BYTE_W-1:0]   tx_byte,
  output logic                last,
  output logic [1:0]          queued,
  output logic                dropped,
  output logic [PEND_W-1:0]   pending
);

  logic [PTR_W-1:0]    wp;
  logic [PTR_W-1:0]    rp;
  logic [BUDGET_W-1:0] budget_left;
  logic                drop_latch;
  logic [CNT_W-1:0]    remaining;
  logic [PEND_W-1:0]   pend_res;

  logic [PTR_W-1:0]    count;
  logic [PTR_W-1:0]    free_slots;
  logic                is_lf;
  logic                fits;
  logic                store;
  logic [1:0]          q_cnt;
  logic [CNT_W-1:0]    c_ring;
  logic [CNT_W-1:0]    chunk;
  logic                burst_go;
  logic                load_status;

  logic                ram_we;
  logic [BYTE_W-1:0]   ram_wdata;
  logic [BYTE_W-1:0]   ram_rdata;

  always_comb begin
    count      = wp - rp;
    free_slots = PTR_W'(RING_DEPTH - 1) - count;
    is_lf      = (byte_in == LF_BYTE);
    fits       = is_lf ? (free_slots >= PTR_W'(2)) : (free_slots != '0);
    store      = !drop_latch && fits;
    q_cnt      = store ? (is_lf ? 2'd2 : 2'd1) : 2'd0;

    if (count > PTR_W'(BURST_BYTES)) begin
      c_ring = CNT_W'(BURST_BYTES);
    end else begin
      c_ring = CNT_W'(count);
    end
    if (budget_left != BUDGET_UNLIMITED && BUDGET_W'(c_ring) > budget_left) begin
      chunk = CNT_W'(budget_left);
    end else begin
      chunk = c_ring;
    end
    burst_go    = (chunk != '0);
    load_status = dcmd.accept && !(cmd == CMD_READY && burst_go);

    stat.enq_two     = store && is_lf;
    stat.burst_go    = burst_go;
    stat.remain_last = (remaining == CNT_W'(1));
    stat.out_free    = !out_valid || out_ready;

    ram_we    = (dcmd.accept && cmd == CMD_ENQ && store) || dcmd.wr_lf;
    ram_wdata = dcmd.wr_lf ? LF_BYTE : (is_lf ? CR_BYTE : byte_in);
  end

  utrcd_ram #(
    .WIDTH(BYTE_W),
    .DEPTH(RING_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(wp),
    .wdata(ram_wdata),
    .re   (dcmd.rd),
    .raddr(rp),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      wp          <= '0;
      rp          <= '0;
      budget_left <= '0;
      drop_latch  <= 1'b0;
      remaining   <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (ram_we) begin
        wp <= wp + PTR_W'(1);
      end
      if (dcmd.rd) begin
        rp <= rp + PTR_W'(1);
      end
      if (dcmd.accept) begin
        case (cmd)
          CMD_ENQ: begin
            drop_latch <= end_of_write ? 1'b0 : (drop_latch || !fits);
          end
          CMD_DRAIN: begin
            budget_left <= budget;
          end
          CMD_READY: begin
            remaining <= chunk;
            if (budget_left != BUDGET_UNLIMITED) begin
              budget_left <= budget_left - BUDGET_W'(chunk);
            end
          end
          default: begin
            budget_left <= '0;
          end
        endcase
      end
      if (dcmd.ld) begin
        remaining <= remaining - CNT_W'(1);
      end
      if (dcmd.ld || load_status) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (dcmd.accept) begin
      pend_res <= PEND_W'(count - PTR_W'(chunk));
    end
    if (load_status) begin
      kind    <= KIND_STATUS;
      tx_byte <= '0;
      last    <= 1'b1;
      queued  <= (cmd == CMD_ENQ) ? q_cnt : 2'd0;
      dropped <= (cmd == CMD_ENQ) && !store;
      pending <= (cmd == CMD_ENQ) ? PEND_W'(count + PTR_W'(q_cnt)) : PEND_W'(count);
    end else if (dcmd.ld) begin
      kind    <= KIND_BYTE;
      tx_byte <= ram_rdata;
      last    <= stat.remain_last;
      queued  <= 2'd0;
      dropped <= 1'b0;
      pending <= pend_res;
    end
  end

endmodule

// ===== hw/rtl/utrcd_ctrl.sv =====
// Controller: request intake, line-feed second write and burst sequencing.
`timescale 1ns / 1ps
module utrcd_ctrl import utrcd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] cmd,
  input  dp_stat_t   stat,
  output dp_cmd_t    dcmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_LF2  = 2'd1;
  localparam logic [1:0] S_RD   = 2'd2;
  localparam logic [1:0] S_LD   = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  always_comb begin
    in_ready    = (state == S_IDLE) && stat.out_free;
    dcmd.accept = in_valid && in_ready;
    dcmd.wr_lf  = (state == S_LF2);
    dcmd.rd     = (state == S_RD);
    dcmd.ld     = (state == S_LD) && stat.out_free;
    state_next  = state;
    case (state)
      S_IDLE: begin
        if (dcmd.accept) begin
          if (cmd == CMD_ENQ && stat.enq_two) begin
            state_next = S_LF2;
          end else if (cmd == CMD_READY && stat.burst_go) begin
            state_next = S_RD;
          end
        end
      end
      S_LF2: begin
        state_next = S_IDLE;
      end
      S_RD: begin
        state_next = S_LD;
      end
      S_LD: begin
        if (dcmd.ld) begin
          state_next = stat.remain_last ? S_IDLE : S_RD;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== hw/rtl/uart_tx_ring_crlf_drain_top.sv =====
// Top level of the UART transmit ring buffer with CR/LF expansion and burst drain.
// Usage:
//   Input channel (in_valid/in_ready) carries one request: cmd, byte_in,
//   end_of_write, budget. Enqueue stores byte_in (a line feed as CR then LF);
//   drain-start loads the byte budget (all ones = no limit); ready sends a
//   burst of up to 16 bytes; not-ready ends the drain.
//   Output channel (out_valid/out_ready) carries results: one status result
//   for enqueue, drain-start, not-ready and an empty burst; one byte result
//   per burst byte, last set on the final one.
//   A status result is valid the cycle after its request is taken.
//   Each burst byte takes a ring memory read, then a load of the result register.
//   Throughput: one request per cycle for status-only requests while results
//   are taken; a line feed that is stored holds intake for its second write;
//   a burst holds intake until its last byte sits in the result register.
//   Reset clears pointers, budget, drop latch and result valid; ring contents
//   are not cleared. When the receiver stalls, the result register holds and
//   intake or the burst waits for it.
`timescale 1ns / 1ps
module uart_tx_ring_crlf_drain_top import utrcd_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          cmd,
  input  logic [BYTE_W-1:0]   byte_in,
  input  logic                end_of_write,
  input  logic [BUDGET_W-1:0] budget,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                kind,
  output logic [BYTE_W-1:0]   tx_byte,
  output logic                last,
  output logic [1:0]          queued,
  output logic                dropped,
  output logic [PEND_W-1:0]   pending
);

  dp_cmd_t  dcmd;
  dp_stat_t stat;

  utrcd_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .cmd     (cmd),
    .stat    (stat),
    .dcmd    (dcmd)
  );

  utrcd_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .dcmd        (dcmd),
    .stat        (stat),
    .cmd         (cmd),
    .byte_in     (byte_in),
    .end_of_write(end_of_write),
    .budget      (budget),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .kind        (kind),
    .tx_byte     (tx_byte),
    .last        (last),
    .queued      (queued),
    .dropped     (dropped),
    .pending     (pending)
  );

endmodule
